// ===== sv/swan_pkg.sv =====
// Shared types, field widths and codes for the sensor window average normalizer.
// No dependencies; every other file of the block refers to it by scoped names.
package swan_pkg;

   // Field widths
   localparam int VAL_W      = 10;
   localparam int CH_FIELD_W = 3;
   localparam int LEVEL_W    = 17;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int CH_CMP_W   = 5;

   // Parameter defaults
   localparam int WINDOW_DEF      = 8;
   localparam int CHANNELS_DEF    = 8;
   localparam int SAMPLE_BITS_DEF = 10;

   localparam logic [LEVEL_W-1:0] NORM_SCALE  = 17'd100;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 17'd1;
   localparam logic [MASK_W-1:0]  CLAMP_RESET = 8'd42;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_SET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_MASK  = 2'd2;

   // Request and bound-set codes
   localparam logic REQ_LOAD   = 1'b1;
   localparam logic SET_SINGLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UPDATE,
      ST_AVERAGE,
      ST_TRACK,
      ST_NORM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic rd;
      logic upd;
   } win_ctl_type;

   typedef struct packed {
      logic full_now;
      logic full_next;
   } win_sts_type;

endpackage

// ===== sv/sensor_window_average_normalizer.sv =====
// Sensor window average normalizer: one request carries one sample (or one bound load)
// for a sensor channel and yields exactly one response. A sample enters its channel's
// ring of WINDOW entries; until the ring has filled the raw sample passes through,
// afterwards the ring sum divided by WINDOW is used. With calibration on, that value
// widens the channel's minimum and maximum in the set chosen by calib_set. The value
// is then scaled to (v-min)*100/(max-min) against the set the request selects, raised
// to at least 1 and capped at 100 on channels whose clamp_mask bit is set; an empty
// range (max not above min) gives level 1 and raises range_fault. Both divisions run
// on one bit-serial divider, one quotient bit per cycle, and that unit sets the rate:
// a sample is averaged and then scaled once its window has filled and only scaled
// before, a range fault saves the scaling division, and a bound load or a channel
// beyond CHANNELS skips both. One request is in flight at a time; the next is
// accepted in the cycle after the response has been handed to the output register,
// whether or not the consumer has taken it yet. Configuration writes take effect at
// once and are meant to be made while no request is in flight.
module sensor_window_average_normalizer #(
   parameter int WINDOW      = swan_pkg::WINDOW_DEF,
   parameter int CHANNELS    = swan_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = swan_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [swan_pkg::CH_FIELD_W-1:0] req_channel,
   input  logic [swan_pkg::VAL_W-1:0]      req_sample,
   input  logic                            req_use_single_line,
   input  logic                            req_load_set,
   input  logic [swan_pkg::VAL_W-1:0]      req_load_min,
   input  logic [swan_pkg::VAL_W-1:0]      req_load_max,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swan_pkg::CH_FIELD_W-1:0] rsp_out_channel,
   output logic [swan_pkg::VAL_W-1:0]      rsp_filtered_value,
   output logic [swan_pkg::LEVEL_W-1:0]    rsp_level,
   output logic                            rsp_window_full,
   output logic                            rsp_range_fault,
   // configuration port
   input  logic                            csr_write_en,
   input  logic [swan_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swan_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int VAL_W    = swan_pkg::VAL_W;
   localparam int CHF_W    = swan_pkg::CH_FIELD_W;
   localparam int LEVEL_W  = swan_pkg::LEVEL_W;
   localparam int MASK_W   = swan_pkg::MASK_W;
   localparam int CH_CMP_W = swan_pkg::CH_CMP_W;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W    = VAL_W + $clog2(WINDOW);

   swan_pkg::state_type state_ff, state_in;

   // configuration registers
   logic              calibrating_ff;
   logic              calib_set_ff;
   logic [MASK_W-1:0] clamp_mask_ff;

   // request held for the whole run
   logic             type_ff;
   logic [CHF_W-1:0] ch_ff;
   logic [VAL_W-1:0] smp_ff, smp_in;
   logic             use_single_ff;
   logic             load_set_ff;
   logic [VAL_W-1:0] load_min_ff;
   logic [VAL_W-1:0] load_max_ff;

   // result under construction
   logic [VAL_W-1:0]   value_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               full_ff;
   logic               fault_ff;

   // output register
   logic               rsp_valid_ff;
   logic [CHF_W-1:0]   rsp_channel_ff;
   logic [VAL_W-1:0]   rsp_value_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_full_ff;
   logic               rsp_fault_ff;

   // bound sets, zero from reset until loaded or widened by calibration
   logic [VAL_W-1:0] dmin_ff [CHANNELS];
   logic [VAL_W-1:0] dmax_ff [CHANNELS];
   logic [VAL_W-1:0] smin_ff [CHANNELS];
   logic [VAL_W-1:0] smax_ff [CHANNELS];

   logic [CH_CMP_W-1:0] ch_ext;
   logic [CH_W-1:0]     ch_idx;
   logic                ch_ok;
   logic                is_load;
   logic                req_accept;
   logic                out_free;
   logic                rsp_load;

   swan_pkg::win_ctl_type win_ctl;
   swan_pkg::win_sts_type win_sts;
   logic [SUM_W-1:0]      sum_next;

   logic               div_start;
   logic [LEVEL_W-1:0] div_dividend;
   logic [VAL_W-1:0]   div_divisor;
   logic               div_done;
   logic [LEVEL_W-1:0] div_quotient;

   logic [VAL_W-1:0]   lo, hi, tmin, tmax, x, diff;
   logic               empty;
   logic [LEVEL_W-1:0] norm_num;
   logic [LEVEL_W-1:0] lvl_raised, lvl_final;

   // ---------------------------------------------------------------------------------
   // Decode of the held request
   // ---------------------------------------------------------------------------------
   always_comb begin
      ch_ext     = CH_CMP_W'(ch_ff);
      ch_idx     = ch_ext[CH_W-1:0];
      ch_ok      = ch_ext < CH_CMP_W'(CHANNELS);
      is_load    = type_ff == swan_pkg::REQ_LOAD;
      req_accept = req_valid && req_ready;
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // mask the incoming sample down to SAMPLE_BITS
   always_comb begin
      for (int i = 0; i < VAL_W; i++) begin
         smp_in[i] = req_sample[i] & (i < SAMPLE_BITS);
      end
   end

   // ---------------------------------------------------------------------------------
   // Normalization datapath
   // ---------------------------------------------------------------------------------
   always_comb begin
      lo       = use_single_ff ? smin_ff[ch_idx] : dmin_ff[ch_idx];
      hi       = use_single_ff ? smax_ff[ch_idx] : dmax_ff[ch_idx];
      tmin     = calib_set_ff ? smin_ff[ch_idx] : dmin_ff[ch_idx];
      tmax     = calib_set_ff ? smax_ff[ch_idx] : dmax_ff[ch_idx];
      empty    = hi <= lo;
      // raise a sample below the minimum to the minimum
      x        = (value_ff < lo) ? lo : value_ff;
      diff     = x - lo;
      norm_num = LEVEL_W'(diff) * swan_pkg::NORM_SCALE;
      lvl_raised = (div_quotient == '0) ? swan_pkg::LEVEL_ONE : div_quotient;
      if (clamp_mask_ff[ch_ff] && (lvl_raised > swan_pkg::NORM_SCALE)) begin
         lvl_final = swan_pkg::NORM_SCALE;
      end else begin
         lvl_final = lvl_raised;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swan_pkg::ST_IDLE: begin
            if (req_accept) state_in = swan_pkg::ST_DECODE;
         end
         swan_pkg::ST_DECODE: begin
            if (!ch_ok || is_load) state_in = swan_pkg::ST_DONE;
            else                   state_in = swan_pkg::ST_UPDATE;
         end
         swan_pkg::ST_UPDATE: begin
            if (win_sts.full_next) state_in = swan_pkg::ST_AVERAGE;
            else                   state_in = swan_pkg::ST_TRACK;
         end
         swan_pkg::ST_AVERAGE: begin
            if (div_done) state_in = swan_pkg::ST_TRACK;
         end
         swan_pkg::ST_TRACK: begin
            state_in = swan_pkg::ST_NORM;
         end
         swan_pkg::ST_NORM: begin
            if (empty) state_in = swan_pkg::ST_DONE;
            else       state_in = swan_pkg::ST_DIVIDE;
         end
         swan_pkg::ST_DIVIDE: begin
            if (div_done) state_in = swan_pkg::ST_DONE;
         end
         swan_pkg::ST_DONE: begin
            if (out_free) state_in = swan_pkg::ST_IDLE;
         end
         default: begin
            state_in = swan_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------------------
   always_comb begin
      req_ready    = 1'b0;
      win_ctl      = '0;
      div_start    = 1'b0;
      div_dividend = norm_num;
      div_divisor  = hi - lo;
      rsp_load     = 1'b0;
      case (state_ff)
         swan_pkg::ST_IDLE: begin
            // hold off requests while reset is applied
            req_ready = !reset;
         end
         swan_pkg::ST_DECODE: begin
            // fetch the ring entry about to be overwritten
            win_ctl.rd = ch_ok && !is_load;
         end
         swan_pkg::ST_UPDATE: begin
            win_ctl.upd  = 1'b1;
            div_start    = win_sts.full_next;
            div_dividend = LEVEL_W'(sum_next);
            div_divisor  = VAL_W'(WINDOW);
         end
         swan_pkg::ST_NORM: begin
            div_start = !empty;
         end
         swan_pkg::ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) state_ff <= swan_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff <= 1'b0;
         calib_set_ff   <= 1'b0;
         clamp_mask_ff  <= swan_pkg::CLAMP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            swan_pkg::CSR_CALIBRATING: calibrating_ff <= csr_wdata[0];
            swan_pkg::CSR_CALIB_SET:   calib_set_ff   <= csr_wdata[0];
            swan_pkg::CSR_CLAMP_MASK:  clamp_mask_ff  <= csr_wdata[MASK_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // hold the request and build the result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff       <= req_type;
         ch_ff         <= req_channel;
         smp_ff        <= smp_in;
         use_single_ff <= req_use_single_line;
         load_set_ff   <= req_load_set;
         load_min_ff   <= req_load_min;
         load_max_ff   <= req_load_max;
      end
      case (state_ff)
         swan_pkg::ST_DECODE: begin
            value_ff <= '0;
            level_ff <= swan_pkg::LEVEL_ONE;
            fault_ff <= 1'b0;
            full_ff  <= ch_ok ? win_sts.full_now : 1'b0;
         end
         swan_pkg::ST_UPDATE: begin
            full_ff <= win_sts.full_next;
            // pass the raw sample through until the window has filled
            if (!win_sts.full_next) value_ff <= smp_ff;
         end
         swan_pkg::ST_AVERAGE: begin
            if (div_done) value_ff <= div_quotient[VAL_W-1:0];
         end
         swan_pkg::ST_NORM: begin
            fault_ff <= empty;
            level_ff <= swan_pkg::LEVEL_ONE;
         end
         swan_pkg::ST_DIVIDE: begin
            if (div_done) level_ff <= lvl_final;
         end
         default: begin
         end
      endcase
   end

   // bound sets: loads and calibration tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            dmin_ff[i] <= '0;
            dmax_ff[i] <= '0;
            smin_ff[i] <= '0;
            smax_ff[i] <= '0;
         end
      end else begin
         if ((state_ff == swan_pkg::ST_DECODE) && ch_ok && is_load) begin
            if (load_set_ff == swan_pkg::SET_SINGLE) begin
               smin_ff[ch_idx] <= load_min_ff;
               smax_ff[ch_idx] <= load_max_ff;
            end else begin
               dmin_ff[ch_idx] <= load_min_ff;
               dmax_ff[ch_idx] <= load_max_ff;
            end
         end
         if ((state_ff == swan_pkg::ST_TRACK) && calibrating_ff) begin
            if (calib_set_ff == swan_pkg::SET_SINGLE) begin
               if (value_ff > tmax) smax_ff[ch_idx] <= value_ff;
               if (value_ff < tmin) smin_ff[ch_idx] <= value_ff;
            end else begin
               if (value_ff > tmax) dmax_ff[ch_idx] <= value_ff;
               if (value_ff < tmin) dmin_ff[ch_idx] <= value_ff;
            end
         end
      end
   end

   // output register: advance when free, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_channel_ff <= ch_ff;
         rsp_value_ff   <= value_ff;
         rsp_level_ff   <= level_ff;
         rsp_full_ff    <= full_ff;
         rsp_fault_ff   <= fault_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_level          = rsp_level_ff;
   assign rsp_window_full    = rsp_full_ff;
   assign rsp_range_fault    = rsp_fault_ff;

   // ---------------------------------------------------------------------------------
   // Sub-units
   // ---------------------------------------------------------------------------------
   swan_win #(
      .WINDOW   (WINDOW),
      .CHANNELS (CHANNELS)
   ) u_win (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .ch_idx   (ch_idx),
      .smp      (smp_ff),
      .sts      (win_sts),
      .sum_next (sum_next)
   );

   swan_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

// ===== sv/swan_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle through a shift register.
// Depends on swan_pkg for the dividend and divisor widths.
module swan_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [swan_pkg::LEVEL_W-1:0] dividend,
   input  logic [swan_pkg::VAL_W-1:0]   divisor,
   output logic                         done,
   output logic [swan_pkg::LEVEL_W-1:0] quotient
);

   localparam int NUM_W = swan_pkg::LEVEL_W;
   localparam int DEN_W = swan_pkg::VAL_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             take;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      take    = rem_sh >= {1'b0, den_ff};
      rem_in  = take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/swan_win.sv =====
// Per-channel sample ring, write index, running sum and fill flag.
// Depends on swan_pkg for widths and the control and status structs.
module swan_win #(
   parameter int  WINDOW   = swan_pkg::WINDOW_DEF,
   parameter int  CHANNELS = swan_pkg::CHANNELS_DEF,
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int SUM_W    = swan_pkg::VAL_W + $clog2(WINDOW)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swan_pkg::win_ctl_type      ctl,
   input  logic [CH_W-1:0]            ch_idx,
   input  logic [swan_pkg::VAL_W-1:0] smp,
   output swan_pkg::win_sts_type      sts,
   output logic [SUM_W-1:0]           sum_next
);

   localparam int VAL_W  = swan_pkg::VAL_W;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ADDR_W = CH_W + IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [VAL_W-1:0]    ring [DEPTH];
   logic [IDX_W-1:0]    widx_ff [CHANNELS];
   logic [IDX_W-1:0]    widx_in;
   logic [SUM_W-1:0]    sum_ff [CHANNELS];
   logic [CHANNELS-1:0] filled_ff;
   logic [VAL_W-1:0]    old_ff;
   logic [ADDR_W-1:0]   addr;
   logic                last;

   always_comb begin
      addr     = {ch_idx, widx_ff[ch_idx]};
      last     = widx_ff[ch_idx] == IDX_W'(WINDOW - 1);
      widx_in  = last ? '0 : widx_ff[ch_idx] + 1'b1;
      // drop the oldest sample only once the ring holds a full window
      sum_next = sum_ff[ch_idx] - (filled_ff[ch_idx] ? SUM_W'(old_ff) : '0) + SUM_W'(smp);
      sts.full_now  = filled_ff[ch_idx];
      sts.full_next = filled_ff[ch_idx] | last;
   end

   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         ring[addr] <= smp;
      end
      if (ctl.rd) begin
         old_ff <= ring[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            widx_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
         filled_ff <= '0;
      end else if (ctl.upd) begin
         widx_ff[ch_idx]   <= widx_in;
         sum_ff[ch_idx]    <= sum_next;
         filled_ff[ch_idx] <= sts.full_next;
      end
   end

endmodule

// ===== sv/swan_chk.sv =====
// Port-level checker for the sensor window average normalizer, with its bind.
// Depends on swan_pkg for the port widths.
module swan_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [swan_pkg::CH_FIELD_W-1:0] rsp_out_channel,
   input logic [swan_pkg::VAL_W-1:0]      rsp_filtered_value,
   input logic [swan_pkg::LEVEL_W-1:0]    rsp_level,
   input logic                            rsp_window_full,
   input logic                            rsp_range_fault
);

   // one request in flight: ready drops straight after an acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_level)
                                     && $stable(rsp_out_channel)
                                     && $stable(rsp_filtered_value)
                                     && $stable(rsp_window_full)
                                     && $stable(rsp_range_fault)))
      else $error("stalled response changed");

   // level is never below one
   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level != '0))
      else $error("response level is zero");

   // an empty range forces level one
   a_fault_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_fault) |-> (rsp_level == swan_pkg::LEVEL_ONE))
      else $error("range fault with level other than one");

endmodule

bind sensor_window_average_normalizer swan_chk u_swan_chk (.*);
